### sv/lc3b_pkg.sv
// Package for the LC-3b executor: item kinds, opcodes and shared helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lc3b_pkg;
  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_EXEC  = 2'd1,
    KIND_SETPC = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  localparam logic [3:0] OP_BR   = 4'd0;
  localparam logic [3:0] OP_ADD  = 4'd1;
  localparam logic [3:0] OP_LDB  = 4'd2;
  localparam logic [3:0] OP_STB  = 4'd3;
  localparam logic [3:0] OP_JSR  = 4'd4;
  localparam logic [3:0] OP_AND  = 4'd5;
  localparam logic [3:0] OP_LDW  = 4'd6;
  localparam logic [3:0] OP_STW  = 4'd7;
  localparam logic [3:0] OP_XOR  = 4'd9;
  localparam logic [3:0] OP_JMP  = 4'd12;
  localparam logic [3:0] OP_SHF  = 4'd13;
  localparam logic [3:0] OP_LEA  = 4'd14;
  localparam logic [3:0] OP_TRAP = 4'd15;

  localparam logic [2:0] CC_N = 3'b100;
  localparam logic [2:0] CC_Z = 3'b010;
  localparam logic [2:0] CC_P = 3'b001;

  // ALU operation codes for the shared unit
  typedef enum logic [2:0] {
    ALU_ADD, ALU_AND, ALU_XOR, ALU_SHL, ALU_SHRL, ALU_SHRA
  } alu_op_t;

  function automatic logic [2:0] codes_of(input logic [15:0] v);
    if (v == 16'd0) return CC_Z;
    return v[15] ? CC_N : CC_P;
  endfunction
endpackage
`default_nettype wire

### sv/lc3b_instruction_executor_top.sv
// LC-3b executor top: sequencer, register file, word memory and result register.
// Depends on lc3b_pkg and lc3b_alu.
//
//  channel | handshake            | payload                                   | dir
//  request | valid, ready         | kind, address, write_data                 | in
//  result  | out_valid, out_ready | pc_after, cond_codes, halted, ... , lanes | out
//
// Program load, set PC, halt and an unknown kind go from S_IDLE straight to S_DONE;
// an execute steps through fetch, fetch wait, decode, execute, memory access and
// wait (LDB, LDW, STB, STW and TRAP only), write back and result.
// After reset a clearing pass writes zero to every word, during which ready
// stays low. A finished request moves into the result register, so the next
// request runs while a result waits; a second finished request holds in S_DONE
// until the waiting result is taken.
`timescale 1ns / 1ps
`default_nettype none
module lc3b_instruction_executor_top #(
  parameter int MEM_WORDS = 32768
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        valid,
  output logic             ready,
  input  wire logic [1:0]  kind,
  input  wire logic [15:0] address,
  input  wire logic [15:0] write_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      pc_after,
  output logic [2:0]       cond_codes,
  output logic             halted,
  output logic [15:0]      instruction,
  output logic             reg_written,
  output logic [2:0]       reg_index,
  output logic [15:0]      reg_value,
  output logic             mem_written,
  output logic [15:0]      mem_address,
  output logic [15:0]      mem_value,
  output logic [1:0]       mem_byte_lanes
);
  import lc3b_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_FETCH, S_FWAIT, S_DECODE, S_EXEC, S_MEM, S_MWAIT,
    S_WB, S_DONE
  } state_t;

  state_t      state;
  logic [AW:0] clr_cnt;
  logic [15:0] mem [MEM_WORDS];
  logic [15:0] rdata;
  logic [15:0] rf [8];
  logic [15:0] pc;
  logic [2:0]  cc;
  logic [15:0] ir;
  logic [15:0] ea;
  logic [15:0] rval;
  logic        rw, cw, mw;
  logic        hlt;
  logic [2:0]  dr;
  logic [15:0] mval;
  logic [1:0]  lanes;
  logic        load_out;

  // memory port control (one write and one read per cycle)
  logic        m_we;
  logic [16:0] m_widx;
  logic [16:0] m_ridx;
  logic [15:0] m_wd;
  logic [1:0]  m_lanes;
  logic        r_oob;

  // shared ALU
  alu_op_t     alu_op;
  logic [15:0] alu_a, alu_b, alu_y;

  lc3b_alu u_alu (.op(alu_op), .a(alu_a), .b(alu_b), .y(alu_y));

  // decoded fields
  logic [3:0]  op;
  logic [15:0] s1, opnd, off6, off6w, off9, off11;
  assign op    = ir[15:12];
  assign s1    = rf[ir[8:6]];
  assign opnd  = ir[5] ? {{11{ir[4]}}, ir[4:0]} : rf[ir[2:0]];
  assign off6  = {{10{ir[5]}}, ir[5:0]};
  assign off6w = {{9{ir[5]}}, ir[5:0], 1'b0};
  assign off9  = {{6{ir[8]}}, ir[8:0], 1'b0};
  assign off11 = {{4{ir[10]}}, ir[10:0], 1'b0};

  // ALU operand selection per state
  always_comb begin
    alu_op = ALU_ADD;
    alu_a  = pc;
    alu_b  = 16'd2;
    if (state == S_EXEC) begin
      unique case (op)
        OP_ADD: begin alu_a = s1; alu_b = opnd; end
        OP_AND: begin alu_op = ALU_AND; alu_a = s1; alu_b = opnd; end
        OP_XOR: begin alu_op = ALU_XOR; alu_a = s1; alu_b = opnd; end
        OP_SHF: begin
          alu_a = s1;
          alu_b = {12'd0, ir[3:0]};
          alu_op = !ir[4] ? ALU_SHL : (!ir[5] ? ALU_SHRL : ALU_SHRA);
        end
        OP_BR, OP_LEA: begin alu_a = pc; alu_b = off9; end
        OP_JSR: begin alu_a = pc; alu_b = off11; end
        OP_LDB, OP_STB: begin alu_a = s1; alu_b = off6; end
        OP_LDW, OP_STW: begin alu_a = s1; alu_b = off6w; end
        default: begin alu_a = pc; alu_b = 16'd0; end
      endcase
    end
  end

  // memory port address and write data
  always_comb begin
    m_we    = 1'b0;
    m_widx  = 17'd0;
    m_wd    = 16'd0;
    m_lanes = 2'b11;
    m_ridx  = {2'b0, pc[15:1]};
    unique case (state)
      S_CLEAR: begin m_we = 1'b1; m_widx = 17'(clr_cnt); end
      S_IDLE: begin
        m_we   = valid && kind == KIND_WRITE;
        m_widx = {2'b0, address[15:1]};
        m_wd   = write_data;
      end
      S_MEM: begin
        if (op == OP_TRAP) m_ridx = {9'd0, ir[7:0]};
        else m_ridx = {2'b0, ea[15:1]};
        m_we    = (op == OP_STB) || (op == OP_STW);
        m_widx  = {2'b0, ea[15:1]};
        m_wd    = (op == OP_STB) ? {mval[7:0], mval[7:0]} : mval;
        m_lanes = lanes;
      end
      default: ;
    endcase
  end

  // word memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (m_we && m_widx < 17'(MEM_WORDS)) begin
      if (m_lanes[0]) mem[m_widx[AW-1:0]][7:0]  <= m_wd[7:0];
      if (m_lanes[1]) mem[m_widx[AW-1:0]][15:8] <= m_wd[15:8];
    end
    rdata <= mem[m_ridx[AW-1:0]];
    r_oob <= m_ridx >= 17'(MEM_WORDS);
  end

  logic [15:0] rd_word;
  assign rd_word = r_oob ? 16'd0 : rdata;

  assign ready = (state == S_IDLE);

  // a request is finished and the result slot is empty or being emptied this cycle
  assign load_out = (state == S_DONE) && (!out_valid || out_ready);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      pc        <= 16'd0;
      cc        <= CC_Z;
      out_valid <= 1'b0;
      for (int i = 0; i < 8; i++) rf[i] <= 16'd0;
    end else begin
      // result register: load a finished request, drop a taken one
      if (load_out) begin
        out_valid      <= 1'b1;
        pc_after       <= pc;
        cond_codes     <= cc;
        halted         <= hlt;
        instruction    <= ir;
        reg_written    <= rw;
        reg_index      <= rw ? dr : 3'd0;
        reg_value      <= rw ? rval : 16'd0;
        mem_written    <= mw;
        mem_address    <= !mw ? 16'd0 : (lanes == 2'b11 ? {ea[15:1], 1'b0} : ea);
        mem_value      <= mw ? mval : 16'd0;
        mem_byte_lanes <= mw ? lanes : 2'd0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (AW+1)'(MEM_WORDS - 1)) state <= S_IDLE;
        end
        S_IDLE: if (valid) begin
          rw <= 1'b0; mw <= 1'b0; cw <= 1'b0;
          ir <= 16'd0;
          hlt <= (kind == KIND_EXEC) && (pc == 16'd0);
          state <= (kind == KIND_EXEC && pc != 16'd0) ? S_FETCH : S_DONE;
          if (kind == KIND_SETPC) pc <= address;
        end
        S_FETCH: state <= S_FWAIT;
        S_FWAIT: begin
          ir <= rd_word;
          pc <= alu_y;
          state <= S_DECODE;
        end
        S_DECODE: state <= S_EXEC;
        S_EXEC: begin
          ea <= alu_y;
          dr <= ir[11:9];
          state <= S_WB;
          unique case (op)
            OP_ADD, OP_AND, OP_XOR, OP_SHF: begin
              rw <= 1'b1; cw <= 1'b1; rval <= alu_y;
            end
            OP_BR: if ((ir[11:9] & cc) != 3'd0) pc <= alu_y;
            OP_JMP: pc <= s1;
            OP_JSR: begin
              rw <= 1'b1; dr <= 3'd7; rval <= pc;
              pc <= ir[11] ? alu_y : s1;
            end
            OP_LEA: begin rw <= 1'b1; rval <= alu_y; end
            OP_LDB, OP_LDW: begin rw <= 1'b1; cw <= 1'b1; state <= S_MEM; end
            OP_STB: begin
              mw <= 1'b1; mval <= {8'd0, rf[ir[11:9]][7:0]};
              lanes <= alu_y[0] ? 2'b10 : 2'b01; state <= S_MEM;
            end
            OP_STW: begin
              mw <= 1'b1; mval <= rf[ir[11:9]]; lanes <= 2'b11; state <= S_MEM;
            end
            OP_TRAP: begin
              rw <= 1'b1; dr <= 3'd7; rval <= pc; state <= S_MEM;
            end
            default: ;
          endcase
        end
        S_MEM: state <= S_MWAIT;
        S_MWAIT: begin
          state <= S_WB;
          if (op == OP_TRAP) pc <= rd_word;
          else if (op == OP_LDW) rval <= rd_word;
          else if (op == OP_LDB)
            rval <= ea[0] ? {{8{rd_word[15]}}, rd_word[15:8]}
                          : {{8{rd_word[7]}}, rd_word[7:0]};
        end
        S_WB: begin
          if (rw) begin
            rf[dr] <= rval;
            if (cw) cc <= codes_of(rval);
          end
          state <= S_DONE;
        end
        S_DONE: if (load_out) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### sv/lc3b_alu.sv
// Shared arithmetic unit: add, logic and shifts, used for the executor's PC, address and data math.
// Depends on lc3b_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lc3b_alu (
  input  wire lc3b_pkg::alu_op_t op,
  input  wire logic [15:0]       a,
  input  wire logic [15:0]       b,
  output logic [15:0]            y
);
  import lc3b_pkg::*;

  always_comb begin
    case (op)
      ALU_ADD:  y = a + b;
      ALU_AND:  y = a & b;
      ALU_XOR:  y = a ^ b;
      ALU_SHL:  y = a << b[3:0];
      ALU_SHRL: y = a >> b[3:0];
      ALU_SHRA: y = 16'($signed(a) >>> b[3:0]);
      default:  y = a + b;
    endcase
  end
endmodule
`default_nettype wire

### sv/lc3b_checker.sv
// Port-level checker for the LC-3b executor, bound to the top level.
// Depends on lc3b_instruction_executor_top ports only.
`timescale 1ns / 1ps
`default_nettype none
module lc3b_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        valid,
  input wire logic        ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        halted,
  input wire logic [15:0] instruction,
  input wire logic        reg_written,
  input wire logic        mem_written,
  input wire logic [1:0]  mem_byte_lanes
);
  // an accepted request makes ready low in the next cycle
  a_one: assert property (@(posedge clk) disable iff (rst) valid && ready |=> !ready)
    else $error("ready right after accepting a request");
  // a halt reports no instruction and no writes
  a_halt: assert property (@(posedge clk) disable iff (rst)
    out_valid && halted |-> instruction == 16'd0 && !reg_written && !mem_written)
    else $error("halt with side effects");
  // a store reports lanes, no store reports none
  a_lanes: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (mem_written == (mem_byte_lanes != 2'd0)))
    else $error("lane mismatch");
  // result held until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(instruction))
    else $error("result dropped");
endmodule

bind lc3b_instruction_executor_top lc3b_checker u_chk (
  .clk(clk), .rst(rst), .valid(valid), .ready(ready), .out_valid(out_valid),
  .out_ready(out_ready), .halted(halted), .instruction(instruction),
  .reg_written(reg_written), .mem_written(mem_written), .mem_byte_lanes(mem_byte_lanes)
);
`default_nettype wire

### dv/tb_top.sv
// Testbench for lc3b_instruction_executor_top: random and directed program loads,
// PC sets and instruction steps, checked against an in-bench LC-3b predictor.
// Depends on lc3b_pkg and the executor RTL.
`timescale 1ns / 1ps
module tb_top;
  import lc3b_pkg::*;

  localparam int MEMW = 32768;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] address;
    logic [15:0] write_data;
  } request_t;

  typedef struct packed {
    logic [15:0] pc_after;
    logic [2:0]  cond_codes;
    logic        halted;
    logic [15:0] instruction;
    logic        reg_written;
    logic [2:0]  reg_index;
    logic [15:0] reg_value;
    logic        mem_written;
    logic [15:0] mem_address;
    logic [15:0] mem_value;
    logic [1:0]  mem_byte_lanes;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic valid = 1'b0;
  logic ready;
  logic [1:0] kind = '0;
  logic [15:0] address = '0;
  logic [15:0] write_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] pc_after, instruction, reg_value, mem_address, mem_value;
  logic [2:0] cond_codes, reg_index;
  logic halted, reg_written, mem_written;
  logic [1:0] mem_byte_lanes;

  // predictor state
  logic [15:0] shadow_mem [MEMW];
  logic [15:0] shadow_regs [8];
  logic [15:0] shadow_pc;
  logic [2:0]  shadow_cc;

  request_t pending_reqs[$];
  outcome_t expected_outcomes[$];
  int mismatches = 0;
  int checked = 0;
  int execs = 0;
  longint cycles = 0;
  bit stim_done = 1'b0;

  lc3b_instruction_executor_top dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [15:0] sx(input logic [15:0] v, input int bits);
    logic [15:0] r;
    r = v;
    for (int i = bits; i < 16; i++) r[i] = v[bits-1];
    return r;
  endfunction

  function automatic logic [15:0] mem_rd(input logic [15:0] byte_addr);
    int idx;
    idx = int'(byte_addr >> 1);
    return (idx < MEMW) ? shadow_mem[idx] : 16'h0;
  endfunction

  function automatic logic [2:0] flags_for(input logic [15:0] v);
    if (v == 16'h0) return CC_Z;
    return v[15] ? CC_N : CC_P;
  endfunction

  // Apply one request to the shadow machine and return the outcome.
  function automatic outcome_t step_lc3b(input request_t rq);
    outcome_t o;
    logic [15:0] ir, pc, s1, opnd, ea, rval, b;
    logic [3:0] op;
    logic [2:0] dr;
    logic rw, cc;
    int idx;
    o = '0;
    rw = 0; cc = 0; rval = 0;
    if (rq.kind == KIND_WRITE) begin
      idx = int'(rq.address >> 1);
      if (idx < MEMW) shadow_mem[idx] = rq.write_data;
    end else if (rq.kind == KIND_SETPC) begin
      shadow_pc = rq.address;
    end else if (rq.kind == KIND_EXEC) begin
      if (shadow_pc == 16'h0) begin
        o.halted = 1'b1;
      end else begin
        ir = mem_rd(shadow_pc);
        pc = shadow_pc + 16'd2;
        op = ir[15:12];
        dr = ir[11:9];
        s1 = shadow_regs[ir[8:6]];
        opnd = ir[5] ? sx(ir, 5) : shadow_regs[ir[2:0]];
        o.instruction = ir;
        case (op)
          OP_ADD: begin rw = 1; cc = 1; rval = s1 + opnd; end
          OP_AND: begin rw = 1; cc = 1; rval = s1 & opnd; end
          OP_XOR: begin rw = 1; cc = 1; rval = s1 ^ opnd; end
          OP_SHF: begin
            rw = 1; cc = 1;
            if (!ir[4]) rval = s1 << ir[3:0];
            else if (!ir[5]) rval = s1 >> ir[3:0];
            else rval = $signed(s1) >>> ir[3:0];
          end
          OP_BR: if (ir[11:9] & shadow_cc) pc = pc + (sx(ir, 9) << 1);
          OP_JMP: pc = s1;
          OP_JSR: begin
            rw = 1; dr = 3'd7; rval = pc;
            pc = ir[11] ? pc + (sx(ir, 11) << 1) : s1;
          end
          OP_LEA: begin rw = 1; rval = pc + (sx(ir, 9) << 1); end
          OP_LDB: begin
            ea = s1 + sx(ir, 6);
            rval = mem_rd(ea);
            rval = ea[0] ? sx({8'h0, rval[15:8]}, 8) : sx({8'h0, rval[7:0]}, 8);
            rw = 1; cc = 1;
          end
          OP_LDW: begin
            ea = s1 + (sx(ir, 6) << 1);
            rval = mem_rd(ea);
            rw = 1; cc = 1;
          end
          OP_STB: begin
            b = {8'h0, shadow_regs[dr][7:0]};
            ea = s1 + sx(ir, 6);
            idx = int'(ea >> 1);
            if (idx < MEMW) begin
              if (ea[0]) shadow_mem[idx][15:8] = b[7:0];
              else shadow_mem[idx][7:0] = b[7:0];
            end
            o.mem_written = 1; o.mem_address = ea; o.mem_value = b;
            o.mem_byte_lanes = ea[0] ? 2'd2 : 2'd1;
          end
          OP_STW: begin
            ea = s1 + (sx(ir, 6) << 1);
            idx = int'(ea >> 1);
            if (idx < MEMW) shadow_mem[idx] = shadow_regs[dr];
            o.mem_written = 1; o.mem_address = {ea[15:1], 1'b0};
            o.mem_value = shadow_regs[dr]; o.mem_byte_lanes = 2'd3;
          end
          OP_TRAP: begin
            rw = 1; dr = 3'd7; rval = pc;
            pc = shadow_mem[ir[7:0]];
          end
          default: ;
        endcase
        if (rw) begin
          shadow_regs[dr] = rval;
          if (cc) shadow_cc = flags_for(rval);
          o.reg_written = 1; o.reg_index = dr; o.reg_value = rval;
        end
        shadow_pc = pc;
      end
    end
    o.pc_after = shadow_pc;
    o.cond_codes = shadow_cc;
    return o;
  endfunction

  function automatic request_t mk(input logic [1:0] k, input logic [15:0] a,
                                  input logic [15:0] d);
    request_t r;
    r.kind = k; r.address = a; r.write_data = d;
    return r;
  endfunction

  // random instruction; TRAP vectors are biased toward small values (0 to 63)
  function automatic logic [15:0] rand_instr();
    logic [15:0] w;
    w = 16'($urandom);
    if ($urandom_range(0, 3) != 0 && w[15:12] == OP_TRAP)
      w[7:0] = 8'($urandom_range(0, 63));
    return w;
  endfunction

  // Stimulus: directed cases, then small random programs mixed with random single requests.
  initial begin
    logic [15:0] base;
    int n;
    for (int i = 0; i < MEMW; i++) shadow_mem[i] = '0;
    for (int i = 0; i < 8; i++) shadow_regs[i] = '0;
    shadow_pc = 0;
    shadow_cc = CC_Z;
    // directed
    pending_reqs.push_back(mk(KIND_EXEC, 16'h0, 16'h0));        // halt at PC zero
    pending_reqs.push_back(mk(KIND_NONE, 16'hFFFF, 16'hFFFF));  // unknown kind
    pending_reqs.push_back(mk(KIND_WRITE, 16'h3001, 16'h127F)); // ADD r1,r1,-1 (odd load addr)
    pending_reqs.push_back(mk(KIND_WRITE, 16'h3002, 16'h1460)); // ADD r2,r1,0
    pending_reqs.push_back(mk(KIND_WRITE, 16'h3004, 16'hD64F)); // LSHF
    pending_reqs.push_back(mk(KIND_WRITE, 16'h3006, 16'hD87F)); // RSHFA
    pending_reqs.push_back(mk(KIND_WRITE, 16'h3008, 16'h7A7F)); // STW odd ea
    pending_reqs.push_back(mk(KIND_WRITE, 16'h300A, 16'h3A7F)); // STB
    pending_reqs.push_back(mk(KIND_WRITE, 16'h300C, 16'h2E41)); // LDB
    pending_reqs.push_back(mk(KIND_WRITE, 16'h300E, 16'h0000)); // BR never
    pending_reqs.push_back(mk(KIND_WRITE, 16'h3010, 16'h8000)); // unused op
    pending_reqs.push_back(mk(KIND_WRITE, 16'h3012, 16'hF0FF)); // TRAP
    pending_reqs.push_back(mk(KIND_WRITE, 16'hFFFE, 16'hFFFF)); // last word of memory
    pending_reqs.push_back(mk(KIND_SETPC, 16'h3001, 16'h0));    // odd PC
    for (int i = 0; i < 10; i++) pending_reqs.push_back(mk(KIND_EXEC, 16'h0, 16'h0));
    pending_reqs.push_back(mk(KIND_SETPC, 16'hFFFE, 16'h0));
    pending_reqs.push_back(mk(KIND_EXEC, 16'h0, 16'h0));
    // random programs
    while (pending_reqs.size() < 520) begin
      if ($urandom_range(0, 9) == 0) begin
        pending_reqs.push_back(mk(2'($urandom_range(0, 3)), 16'($urandom),
                                  16'($urandom)));
        continue;
      end
      base = 16'($urandom_range(1, 255) << 1);
      if ($urandom_range(0, 7) == 0) base = 16'($urandom);
      n = $urandom_range(2, 8);
      // load n random instructions at base, set the PC there, then step them
      for (int i = 0; i < n; i++)
        pending_reqs.push_back(mk(KIND_WRITE, 16'(base + 2 * i), rand_instr()));
      pending_reqs.push_back(mk(KIND_SETPC, base, 16'h0));
      for (int i = 0; i < n; i++) pending_reqs.push_back(mk(KIND_EXEC, 16'h0, 16'h0));
    end
  end

  // Driver: presents pending requests with random gaps.
  int send_gap = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      valid <= 1'b0;
    end else if (valid && !ready) begin
      // hold
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      valid <= 1'b0;
    end else if (pending_reqs.size() > 0) begin
      request_t rq;
      rq = pending_reqs.pop_front();
      kind <= rq.kind;
      address <= rq.address;
      write_data <= rq.write_data;
      valid <= 1'b1;
      expected_outcomes.push_back(step_lc3b(rq));
      if (rq.kind == KIND_EXEC) execs++;
      send_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) :
                  ($urandom_range(0, 1) ? 0 : $urandom_range(0, 3));
    end else begin
      valid <= 1'b0;
      stim_done <= 1'b1;
    end
  end

  // Monitor: random result stalls and field checks.
  int stall = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        outcome_t got, exp_o;
        got = {pc_after, cond_codes, halted, instruction, reg_written, reg_index,
               reg_value, mem_written, mem_address, mem_value, mem_byte_lanes};
        checked++;
        if (expected_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          exp_o = expected_outcomes.pop_front();
          if (got !== exp_o) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch #%0d: exp %p got %p", checked, exp_o, got);
          end
        end
      end
      if (stall > 0) begin
        stall <= stall - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall <= ($urandom_range(0, 15) == 0) ? $urandom_range(5, 25) :
                 ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
      end
    end
  end

  // Reset, drain and verdict.
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (!(stim_done && expected_outcomes.size() == 0) && cycles < CYCLE_LIMIT)
      @(posedge clk);
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_top failed");
      $finish;
    end else begin
      repeat (20) @(posedge clk);
      $display("checked %0d results, %0d of them instruction steps", checked, execs);
      if (mismatches == 0 && expected_outcomes.size() == 0)
        $display("tb_top passed");
      else
        $display("tb_top failed");
      $finish;
    end
  end
endmodule

### lc3b_instruction_executor_top.f
sv/lc3b_pkg.sv
sv/lc3b_alu.sv
sv/lc3b_instruction_executor_top.sv
sv/lc3b_checker.sv
dv/tb_top.sv
